// File: rtl/core/bech32_segwit_address_encoder_macros.svh
// Assertion macros used by the address encoder checker.
`ifndef BECH32_SEGWIT_ADDRESS_ENCODER_MACROS_SVH
`define BECH32_SEGWIT_ADDRESS_ENCODER_MACROS_SVH

// Clocked assertion, muted while reset is applied.
`define BSE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication shorthand on the same clocking.
`define BSE_IMPLY(label, cond, expr, msg) \
	`BSE_ASSERT(label, (cond) |-> (expr), msg)

`endif

// File: rtl/core/bse_pkg.sv
// Types, constants and checksum helpers of the bech32 address encoder.
package bse_pkg;

	typedef struct packed {
		logic [7:0] program_byte;
		logic       final_byte;
	} bse_in_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       run_end;
		logic       address_end;
		logic       error_code;
	} bse_out_t;

	// Classified item as held in the queue.
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       skip;
		logic       last;
		logic       len_ok;
	} bse_item_t;

	typedef struct packed {
		logic      avail;
		bse_item_t item;
	} bse_head_t;

	typedef struct packed {
		logic [3:0]   last_idx;
		logic [127:0] chars;
	} bse_cfg_t;

	localparam logic [1:0] REG_PREFIX_LENGTH = 2'd0;
	localparam logic [1:0] REG_PREFIX_LOW    = 2'd1;
	localparam logic [1:0] REG_PREFIX_HIGH   = 2'd2;

	localparam logic [5:0] LEN_SHORT = 6'd20;
	localparam logic [5:0] LEN_LONG  = 6'd32;
	localparam logic [5:0] LEN_OVER  = 6'd33;

	localparam logic [6:0] CHAR_ONE = 7'h31;
	localparam logic [6:0] CHAR_Q   = 7'h71;

	localparam logic [29:0] GEN0 = 30'h3b6a57b2;
	localparam logic [29:0] GEN1 = 30'h26508e6d;
	localparam logic [29:0] GEN2 = 30'h1ea119fa;
	localparam logic [29:0] GEN3 = 30'h3d4233dd;
	localparam logic [29:0] GEN4 = 30'h2a1462b3;

	localparam logic [7:0] ALPHABET [0:31] = '{
		"q", "p", "z", "r", "y", "9", "x", "8", "g", "f", "2", "t", "v", "d", "w", "0",
		"s", "3", "j", "n", "5", "4", "k", "h", "c", "e", "6", "m", "u", "a", "7", "l"
	};

	function automatic logic [29:0] bse_feed(logic [29:0] chk, logic [4:0] sym);
		logic [29:0] r;
		r = {chk[24:0], sym};
		if (chk[25]) r = r ^ GEN0;
		if (chk[26]) r = r ^ GEN1;
		if (chk[27]) r = r ^ GEN2;
		if (chk[28]) r = r ^ GEN3;
		if (chk[29]) r = r ^ GEN4;
		return r;
	endfunction

	function automatic logic [6:0] bse_letter(logic [4:0] sym);
		logic [7:0] c;
		c = ALPHABET[sym];
		return c[6:0];
	endfunction

endpackage

// File: rtl/core/bse_front.sv
// Front end: accepts program bytes, tags them with address position, queues them.
module bse_front import bse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      prog_valid,
	output logic      prog_stall,
	input  bse_in_t   prog_item,
	output bse_head_t head,
	input  logic      pop
);

	logic       in_addr_q;
	logic [5:0] count_q;
	logic [5:0] count_before;
	logic [5:0] count_after;
	logic       push;
	bse_item_t  cls;

	bse_item_t  fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign prog_stall = (fill_q == 2'd2);
	assign push = prog_valid && !prog_stall;

	always_comb begin
		count_before = in_addr_q ? count_q : 6'd0;
		count_after  = (count_before >= LEN_LONG) ? LEN_OVER : count_before + 6'd1;
		cls.data   = prog_item.program_byte;
		cls.first  = !in_addr_q;
		cls.skip   = (count_before >= LEN_LONG);
		cls.last   = prog_item.final_byte;
		cls.len_ok = (count_after == LEN_SHORT) || (count_after == LEN_LONG);
	end

	assign head.avail = (fill_q != 2'd0);
	assign head.item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_addr_q <= 1'b0;
			count_q   <= 6'd0;
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			fill_q    <= 2'd0;
		end else begin
			if (push) begin
				fifo_q[wr_ptr_q] <= cls;
				wr_ptr_q <= !wr_ptr_q;
				if (prog_item.final_byte) begin
					in_addr_q <= 1'b0;
					count_q   <= 6'd0;
				end else begin
					in_addr_q <= 1'b1;
					count_q   <= count_after;
				end
			end
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

endmodule

// File: rtl/core/bse_back.sv
// Back end: sequencer that runs the checksum and emits address characters.
module bse_back import bse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bse_head_t head,
	output logic      pop,
	input  bse_cfg_t  cfg,
	output logic      char_valid,
	input  logic      char_stall,
	output bse_out_t  char_item
);

	typedef enum logic [3:0] {
		S_IDLE, S_PHI, S_PSEP, S_PLO, S_PVER, S_PQ,
		S_DATA, S_PAD, S_CZERO, S_CSUM, S_ERR
	} state_t;

	state_t      state_q;
	bse_item_t   item_q;
	logic [29:0] chk_q;
	logic [11:0] acc_q;
	logic [3:0]  pend_q;
	logic [3:0]  idx_q;
	logic [2:0]  cnt_q;
	logic        out_valid_q;
	bse_out_t    out_q;

	logic        go;
	logic [6:0]  pchar;
	logic [3:0]  shift;
	logic [11:0] acc_sh;
	logic [4:0]  dsym;
	logic [3:0]  pend_nxt;
	logic [8:0]  pad_sh;
	logic [4:0]  psym;

	function automatic state_t tail_of(logic last, logic ok, logic [3:0] pend);
		if (!last) return S_IDLE;
		if (!ok) return S_ERR;
		if (pend != 4'd0) return S_PAD;
		return S_CZERO;
	endfunction

	assign go         = !out_valid_q || !char_stall;
	assign pop        = (state_q == S_IDLE) && head.avail;
	assign char_valid = out_valid_q;
	assign char_item  = out_q;

	always_comb begin
		pchar    = cfg.chars[{idx_q, 3'b000} +: 7];
		shift    = pend_q - 4'd5;
		acc_sh   = acc_q >> shift[2:0];
		dsym     = acc_sh[4:0];
		pend_nxt = pend_q - 4'd5;
		pad_sh   = {acc_q[3:0], 5'b00000} >> pend_q[2:0];
		psym     = pad_sh[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			chk_q       <= 30'd1;
			acc_q       <= 12'd0;
			pend_q      <= 4'd0;
			idx_q       <= 4'd0;
			cnt_q       <= 3'd0;
		end else begin
			if (go) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (head.avail) begin
						item_q <= head.item;
						if (head.item.first) begin
							chk_q   <= 30'd1;
							acc_q   <= 12'd0;
							pend_q  <= 4'd0;
							idx_q   <= 4'd0;
							state_q <= S_PHI;
						end else if (!head.item.skip) begin
							acc_q   <= {acc_q[3:0], head.item.data};
							pend_q  <= pend_q + 4'd8;
							state_q <= S_DATA;
						end else begin
							state_q <= tail_of(head.item.last, head.item.len_ok, pend_q);
						end
					end
				end
				S_PHI: begin
					chk_q <= bse_feed(chk_q, {3'b000, pchar[6:5]});
					if (idx_q == cfg.last_idx) begin
						idx_q   <= 4'd0;
						state_q <= S_PSEP;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_PSEP: begin
					chk_q   <= bse_feed(chk_q, 5'd0);
					state_q <= S_PLO;
				end
				S_PLO: begin
					if (go) begin
						chk_q       <= bse_feed(chk_q, pchar[4:0]);
						out_valid_q <= 1'b1;
						out_q       <= '{char_code: pchar, run_end: 1'b0,
							address_end: 1'b0, error_code: 1'b0};
						if (idx_q == cfg.last_idx) state_q <= S_PVER;
						else idx_q <= idx_q + 4'd1;
					end
				end
				S_PVER: begin
					if (go) begin
						chk_q       <= bse_feed(chk_q, 5'd0);
						out_valid_q <= 1'b1;
						out_q       <= '{char_code: CHAR_ONE, run_end: 1'b0,
							address_end: 1'b0, error_code: 1'b0};
						state_q     <= S_PQ;
					end
				end
				S_PQ: begin
					if (go) begin
						out_valid_q <= 1'b1;
						out_q       <= '{char_code: CHAR_Q, run_end: 1'b0,
							address_end: 1'b0, error_code: 1'b0};
						if (!item_q.skip) begin
							acc_q   <= {acc_q[3:0], item_q.data};
							pend_q  <= pend_q + 4'd8;
							state_q <= S_DATA;
						end else begin
							state_q <= tail_of(item_q.last, item_q.len_ok, pend_q);
						end
					end
				end
				S_DATA: begin
					if (go) begin
						chk_q       <= bse_feed(chk_q, dsym);
						out_valid_q <= 1'b1;
						out_q       <= '{char_code: bse_letter(dsym),
							run_end: (pend_nxt < 4'd5) && !item_q.last,
							address_end: 1'b0, error_code: 1'b0};
						pend_q      <= pend_nxt;
						if (pend_nxt < 4'd5)
							state_q <= tail_of(item_q.last, item_q.len_ok, pend_nxt);
					end
				end
				S_PAD: begin
					if (go) begin
						chk_q       <= bse_feed(chk_q, psym);
						out_valid_q <= 1'b1;
						out_q       <= '{char_code: bse_letter(psym), run_end: 1'b0,
							address_end: 1'b0, error_code: 1'b0};
						pend_q      <= 4'd0;
						cnt_q       <= 3'd0;
						state_q     <= S_CZERO;
					end
				end
				S_CZERO: begin
					if (cnt_q == 3'd5) begin
						chk_q   <= bse_feed(chk_q, 5'd0) ^ 30'd1;
						cnt_q   <= 3'd0;
						state_q <= S_CSUM;
					end else begin
						chk_q <= bse_feed(chk_q, 5'd0);
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_CSUM: begin
					if (go) begin
						out_valid_q <= 1'b1;
						out_q       <= '{char_code: bse_letter(chk_q[29:25]),
							run_end: (cnt_q == 3'd5), address_end: (cnt_q == 3'd5),
							error_code: 1'b0};
						chk_q       <= {chk_q[24:0], 5'b00000};
						if (cnt_q == 3'd5) begin
							cnt_q   <= 3'd0;
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				S_ERR: begin
					if (go) begin
						out_valid_q <= 1'b1;
						out_q       <= '{char_code: 7'd0, run_end: 1'b1,
							address_end: 1'b1, error_code: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/bech32_segwit_address_encoder.sv
// Top level of the bech32 segwit v0 address encoder with its register port.
// Takes one witness program byte per item and returns the address characters on the
// char channel. A two-entry queue sits between byte intake and the character
// sequencer, so bytes keep arriving while characters drain. A middle byte leaves the
// queue and then yields one or two characters. The first byte of an address adds the
// prefix checksum and characters. The final byte adds the pad character when bits are
// left over, six checksum rounds and six checksum characters, or one error result
// when the program is not 20 or 32 bytes. Bytes past 32 emit nothing. Registers:
// prefix length at 0x00, characters 0-7 at 0x08, 8-15 at 0x10.
module bech32_segwit_address_encoder import bse_pkg::*; #(
	parameter int PREFIX_MAX_CHARS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        prog_valid,
	output logic        prog_stall,
	input  bse_in_t     prog_item,
	output logic        char_valid,
	input  logic        char_stall,
	output bse_out_t    char_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [4:0]  prefix_length_q;
	logic [63:0] prefix_low_q;
	logic [63:0] prefix_high_q;
	logic [4:0]  len_eff;
	logic        wr_en;
	bse_cfg_t    cfg;
	bse_head_t   head;
	logic        pop;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_length_q <= 5'd2;
			prefix_low_q    <= 64'd25442;
			prefix_high_q   <= 64'd0;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				REG_PREFIX_LENGTH: prefix_length_q <= pwdata[4:0];
				REG_PREFIX_LOW:    prefix_low_q    <= pwdata;
				REG_PREFIX_HIGH:   prefix_high_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_PREFIX_LENGTH: prdata = {59'd0, prefix_length_q};
			REG_PREFIX_LOW:    prdata = prefix_low_q;
			REG_PREFIX_HIGH:   prdata = prefix_high_q;
			default:           prdata = 64'd0;
		endcase
	end

	always_comb begin
		len_eff = prefix_length_q;
		if (len_eff == 5'd0) len_eff = 5'd1;
		if (len_eff > 5'd16) len_eff = 5'd16;
		if (int'(len_eff) > PREFIX_MAX_CHARS) len_eff = 5'(PREFIX_MAX_CHARS);
		cfg.last_idx = 4'(len_eff - 5'd1);
		cfg.chars    = {prefix_high_q, prefix_low_q};
	end

	bse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.prog_valid (prog_valid),
		.prog_stall (prog_stall),
		.prog_item  (prog_item),
		.head       (head),
		.pop        (pop)
	);

	bse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.cfg        (cfg),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item)
	);

endmodule

// File: rtl/core/bse_checker.sv
// Port-level checker for the address encoder, bound to the top level.
`include "bech32_segwit_address_encoder_macros.svh"

module bse_checker import bse_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     char_valid,
	input logic     char_stall,
	input bse_out_t char_item
);

	logic err_shape_ok;

	assign err_shape_ok = char_item.address_end && char_item.run_end &&
		(char_item.char_code == 7'd0);

	`BSE_ASSERT(a_valid_holds, char_valid && char_stall |=> char_valid, "stalled item dropped")
	`BSE_ASSERT(a_item_holds, char_valid && char_stall |=> $stable(char_item), "stalled item changed")
	`BSE_IMPLY(a_err_shape, char_valid && char_item.error_code, err_shape_ok, "malformed error item")
	`BSE_IMPLY(a_end_is_run_end, char_valid && char_item.address_end, char_item.run_end, "bad end")

endmodule

bind bech32_segwit_address_encoder bse_checker u_bse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.char_item  (char_item)
);
